### src/q2dcm_pkg.sv
// types and helpers for the quaternion to rotation matrix pipeline
// no dependencies
`default_nettype none

package q2dcm_pkg;

    localparam int FRAC_BITS = 14;
    localparam int COMP_W    = 16;
    localparam int PROD_W    = 2 * COMP_W;
    // doubled cross products added in pairs need two bits over a product, plus a guard bit
    localparam int SUM_W     = PROD_W + 3;
    localparam int NUM_ENTRY = 9;

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;

    localparam t_sum HALF_LSB = t_sum'(1) <<< (FRAC_BITS - 1);

    // q7.28 sum to q2.14, round half up, then clamp to the entry range
    function automatic t_comp round_sat(input t_sum s);
        t_sum                             t;
        logic signed [SUM_W-FRAC_BITS-1:0] q;
        t = s + HALF_LSB;
        q = t[SUM_W-1:FRAC_BITS];
        if (q > (SUM_W-FRAC_BITS)'(signed'(17'sd32767))) begin
            return t_comp'(16'sh7fff);
        end else if (q < (SUM_W-FRAC_BITS)'(signed'(-17'sd32768))) begin
            return t_comp'(16'sh8000);
        end else begin
            return q[COMP_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

### src/quaternion_to_rotation_matrix.sv
// quaternion (w, x, y, z) in q2.14 to 3x3 direction cosine matrix, fully pipelined
// depends on q2dcm_pkg
`default_nettype none

// Takes a word when i_start is high; o_busy is always low, so a new quaternion may
// enter on every clock. The word goes through four register stages (input register,
// product stage, sum stage, round and saturate stage): its matrix is on the o_entry
// ports, with o_valid high, for a single cycle once it leaves the round and saturate
// stage. The receiver cannot stall.
// i_mode high gives the transpose. Entries can saturate when the quaternion is not of
// unit length. Reset clears only the valid bits.
module quaternion_to_rotation_matrix
    import q2dcm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic        i_mode,
    input  wire logic signed [15:0] i_quat_scalar,
    input  wire logic signed [15:0] i_quat_x,
    input  wire logic signed [15:0] i_quat_y,
    input  wire logic signed [15:0] i_quat_z,
    output logic             o_valid,
    output logic signed [15:0] o_entry_r0c0,
    output logic signed [15:0] o_entry_r0c1,
    output logic signed [15:0] o_entry_r0c2,
    output logic signed [15:0] o_entry_r1c0,
    output logic signed [15:0] o_entry_r1c1,
    output logic signed [15:0] o_entry_r1c2,
    output logic signed [15:0] o_entry_r2c0,
    output logic signed [15:0] o_entry_r2c1,
    output logic signed [15:0] o_entry_r2c2
);

    // valid bits, one per stage
    logic  r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld;
    logic  r_s1_mode, r_s2_mode, r_s3_mode;

    // stage 1: input word
    t_comp r_w, r_x, r_y, r_z;

    // stage 2: squares and plain cross products
    t_prod r_ww, r_xx, r_yy, r_zz;
    t_prod r_wx, r_wy, r_wz, r_xy, r_xz, r_yz;

    // stage 3: exact q7.28 sums, row major
    t_sum  r_m [NUM_ENTRY];
    t_sum  n_m [NUM_ENTRY];

    // stage 4: rounded entries
    t_comp r_e [NUM_ENTRY];
    t_comp n_e [NUM_ENTRY];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_start & ~o_busy;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_mode <= i_mode;
        r_w       <= i_quat_scalar;
        r_x       <= i_quat_x;
        r_y       <= i_quat_y;
        r_z       <= i_quat_z;

        r_s2_mode <= r_s1_mode;
        r_ww      <= r_w * r_w;
        r_xx      <= r_x * r_x;
        r_yy      <= r_y * r_y;
        r_zz      <= r_z * r_z;
        r_wx      <= r_w * r_x;
        r_wy      <= r_w * r_y;
        r_wz      <= r_w * r_z;
        r_xy      <= r_x * r_y;
        r_xz      <= r_x * r_z;
        r_yz      <= r_y * r_z;

        r_s3_mode <= r_s2_mode;
        r_m       <= n_m;

        r_e       <= n_e;
    end

    always_comb begin
        t_sum ww, xx, yy, zz, wx2, wy2, wz2, xy2, xz2, yz2;
        ww  = t_sum'(r_ww);
        xx  = t_sum'(r_xx);
        yy  = t_sum'(r_yy);
        zz  = t_sum'(r_zz);
        wx2 = t_sum'(r_wx) <<< 1;
        wy2 = t_sum'(r_wy) <<< 1;
        wz2 = t_sum'(r_wz) <<< 1;
        xy2 = t_sum'(r_xy) <<< 1;
        xz2 = t_sum'(r_xz) <<< 1;
        yz2 = t_sum'(r_yz) <<< 1;

        n_m[0] = (ww + xx) - (yy + zz);
        n_m[1] = xy2 + wz2;
        n_m[2] = xz2 - wy2;
        n_m[3] = xy2 - wz2;
        n_m[4] = (ww + yy) - (xx + zz);
        n_m[5] = yz2 + wx2;
        n_m[6] = xz2 + wy2;
        n_m[7] = yz2 - wx2;
        n_m[8] = (ww + zz) - (xx + yy);
    end

    // transpose swaps the off-diagonal pairs
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_e[r*3+c] = round_sat(r_s3_mode ? r_m[c*3+r] : r_m[r*3+c]);
            end
        end
    end

    assign o_busy       = 1'b0;
    assign o_valid      = r_s4_vld;
    assign o_entry_r0c0 = r_e[0];
    assign o_entry_r0c1 = r_e[1];
    assign o_entry_r0c2 = r_e[2];
    assign o_entry_r1c0 = r_e[3];
    assign o_entry_r1c1 = r_e[4];
    assign o_entry_r1c2 = r_e[5];
    assign o_entry_r2c0 = r_e[6];
    assign o_entry_r2c1 = r_e[7];
    assign o_entry_r2c2 = r_e[8];

    // a matrix only comes out for a word that went in through i_start
    a_valid_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, 4))
        else $error("matrix without a word four cycles earlier");

    // a pure scalar quaternion gives a diagonal matrix in either mode
    a_scalar_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_quat_x, 4) == 16'sd0 && $past(i_quat_y, 4) == 16'sd0
         && $past(i_quat_z, 4) == 16'sd0)
        |-> (o_entry_r0c1 == 16'sd0 && o_entry_r0c2 == 16'sd0 && o_entry_r1c0 == 16'sd0
             && o_entry_r1c2 == 16'sd0 && o_entry_r2c0 == 16'sd0 && o_entry_r2c1 == 16'sd0))
        else $error("off-diagonal entry nonzero for a scalar quaternion");

    // the zero quaternion gives zeros on the diagonal, which does not depend on mode
    a_zero_quat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_quat_scalar, 4) == 16'sd0 && $past(i_quat_x, 4) == 16'sd0
         && $past(i_quat_y, 4) == 16'sd0 && $past(i_quat_z, 4) == 16'sd0)
        |-> (o_entry_r0c0 == 16'sd0 && o_entry_r1c1 == 16'sd0 && o_entry_r2c2 == 16'sd0))
        else $error("nonzero diagonal for the zero quaternion");

    // one-bit identity: w = 1.0 alone gives the unit matrix
    a_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_quat_scalar, 4) == 16'sd16384 && $past(i_quat_x, 4) == 16'sd0
         && $past(i_quat_y, 4) == 16'sd0 && $past(i_quat_z, 4) == 16'sd0)
        |-> (o_entry_r0c0 == 16'sd16384 && o_entry_r1c1 == 16'sd16384
             && o_entry_r2c2 == 16'sd16384))
        else $error("unit quaternion did not give the unit matrix");

endmodule

`default_nettype wire

### tb/tb_quaternion_to_rotation_matrix.sv
// self-checking testbench for the quaternion to rotation matrix pipeline
// depends on q2dcm_pkg and quaternion_to_rotation_matrix
`timescale 1ns / 1ps

module tb_quaternion_to_rotation_matrix
    import q2dcm_pkg::*;
;

    localparam int PIPE_DEPTH  = 4;
    localparam int STALL_LIMIT = 200;

    typedef logic [NUM_ENTRY-1:0][COMP_W-1:0] t_mat;

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  i_start;
    logic  o_busy;
    logic  i_mode;
    t_comp i_quat_scalar;
    t_comp i_quat_x;
    t_comp i_quat_y;
    t_comp i_quat_z;
    logic  o_valid;
    t_comp o_entry_r0c0, o_entry_r0c1, o_entry_r0c2;
    t_comp o_entry_r1c0, o_entry_r1c1, o_entry_r1c2;
    t_comp o_entry_r2c0, o_entry_r2c1, o_entry_r2c2;

    t_mat expected_mats[$];
    int   mismatch_count = 0;
    int   words_sent     = 0;
    int   mats_checked   = 0;
    int   send_idle_pct  = 0;
    int   stall_cycles   = 0;

    quaternion_to_rotation_matrix i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_mode        (i_mode),
        .i_quat_scalar (i_quat_scalar),
        .i_quat_x      (i_quat_x),
        .i_quat_y      (i_quat_y),
        .i_quat_z      (i_quat_z),
        .o_valid       (o_valid),
        .o_entry_r0c0  (o_entry_r0c0),
        .o_entry_r0c1  (o_entry_r0c1),
        .o_entry_r0c2  (o_entry_r0c2),
        .o_entry_r1c0  (o_entry_r1c0),
        .o_entry_r1c1  (o_entry_r1c1),
        .o_entry_r1c2  (o_entry_r1c2),
        .o_entry_r2c0  (o_entry_r2c0),
        .o_entry_r2c1  (o_entry_r2c1),
        .o_entry_r2c2  (o_entry_r2c2)
    );

    always #4 i_clk = ~i_clk;

    // q7.28 to q2.14, nearest with ties up, clamped
    function automatic t_comp q28_to_entry(input longint s);
        longint q;
        q = (s + 64'sd8192) >>> FRAC_BITS;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return t_comp'(q);
    endfunction

    function automatic t_mat dcm_predict(input logic mode, input t_comp w, input t_comp x,
                                         input t_comp y, input t_comp z);
        longint lw, lx, ly, lz;
        longint ww, xx, yy, zz, wx2, wy2, wz2, xy2, xz2, yz2;
        longint m[NUM_ENTRY];
        t_mat   res;
        lw  = longint'(w);
        lx  = longint'(x);
        ly  = longint'(y);
        lz  = longint'(z);
        ww  = lw * lw;
        xx  = lx * lx;
        yy  = ly * ly;
        zz  = lz * lz;
        wx2 = 2 * lw * lx;
        wy2 = 2 * lw * ly;
        wz2 = 2 * lw * lz;
        xy2 = 2 * lx * ly;
        xz2 = 2 * lx * lz;
        yz2 = 2 * ly * lz;
        m[0] = ww + xx - yy - zz;
        m[1] = xy2 + wz2;
        m[2] = xz2 - wy2;
        m[3] = xy2 - wz2;
        m[4] = ww - xx + yy - zz;
        m[5] = yz2 + wx2;
        m[6] = xz2 + wy2;
        m[7] = yz2 - wx2;
        m[8] = ww - xx - yy + zz;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                // transpose picks the mirrored entry
                res[r*3+c] = q28_to_entry(mode ? m[c*3+r] : m[r*3+c]);
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int entry_idx,
                                   input t_comp got, input t_comp exp_val);
        $display("mismatch: matrix %0d %s r%0dc%0d got %0d expected %0d", mats_checked, what,
                 entry_idx / 3, entry_idx % 3, got, exp_val);
        mismatch_count++;
    endtask

    // called right after a rising edge; returns right after the edge that takes the word
    // or after the idle cycles that follow it
    task automatic send_word(input logic mode, input t_comp w, input t_comp x,
                             input t_comp y, input t_comp z);
        i_start       <= 1'b1;
        i_mode        <= mode;
        i_quat_scalar <= w;
        i_quat_x      <= x;
        i_quat_y      <= y;
        i_quat_z      <= z;
        do @(posedge i_clk); while (o_busy);
        expected_mats.push_back(dcm_predict(mode, w, x, y, z));
        words_sent++;
        // each further cycle idles with the given chance
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic test_directed();
        send_word(1'b0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0);
        send_word(1'b1, 16'sd16384, 16'sd0, 16'sd0, 16'sd0);
        send_word(1'b0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0);
        // quarter turns about each axis, both directions of the mapping
        for (int m = 0; m < 2; m++) begin
            send_word(m[0], 16'sd11585, 16'sd11585, 16'sd0, 16'sd0);
            send_word(m[0], 16'sd11585, 16'sd0, 16'sd11585, 16'sd0);
            send_word(m[0], 16'sd11585, 16'sd0, 16'sd0, -16'sd11585);
        end
        send_word(1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_word(1'b0, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_word(1'b1, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_word(1'b0, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
        send_word(1'b1, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
        send_word(1'b0, -16'sd32768, 16'sd0, 16'sd0, 16'sd0);
        send_word(1'b1, 16'sd0, -16'sd32768, 16'sd32767, 16'sd0);
        // exact half lsb on the off-diagonal, positive and negative
        send_word(1'b0, 16'sd0, 16'sd64, 16'sd64, 16'sd0);
        send_word(1'b0, 16'sd0, 16'sd64, -16'sd64, 16'sd0);
        send_word(1'b1, 16'sd1, 16'sd1, -16'sd1, 16'sd1);
    endtask

    // well-formed rotations, some scaled a little off unit length
    task automatic test_unit_quats(input int count);
        real   v[4];
        real   norm;
        real   scale;
        t_comp q[4];
        for (int n = 0; n < count; n++) begin
            norm = 0.0;
            for (int k = 0; k < 4; k++) begin
                v[k] = real'(int'($urandom_range(0, 65535)) - 32768);
                norm += v[k] * v[k];
            end
            norm  = $sqrt(norm);
            scale = 16384.0;
            if ($urandom_range(0, 3) == 0)
                scale = 16384.0 * (0.9 + 0.2 * real'($urandom_range(0, 1000)) / 1000.0);
            for (int k = 0; k < 4; k++) begin
                q[k] = (norm == 0.0) ? t_comp'(k == 0 ? 16384 : 0)
                                     : t_comp'($rtoi(v[k] / norm * scale));
            end
            send_word(1'($urandom_range(0, 1)), q[0], q[1], q[2], q[3]);
        end
    endtask

    // any bit patterns at all
    task automatic test_raw_quats(input int count);
        for (int n = 0; n < count; n++) begin
            send_word(1'($urandom_range(0, 1)), t_comp'($urandom), t_comp'($urandom),
                      t_comp'($urandom), t_comp'($urandom));
        end
    endtask

    always @(posedge i_clk) begin
        t_mat got;
        t_mat exp_mat;
        if (i_rst_n && o_valid) begin
            got = {o_entry_r2c2, o_entry_r2c1, o_entry_r2c0,
                   o_entry_r1c2, o_entry_r1c1, o_entry_r1c0,
                   o_entry_r0c2, o_entry_r0c1, o_entry_r0c0};
            if (expected_mats.size() == 0) begin
                $display("unexpected matrix word on the output");
                mismatch_count++;
            end else begin
                exp_mat = expected_mats.pop_front();
                for (int k = 0; k < NUM_ENTRY; k++) begin
                    if (got[k] !== exp_mat[k])
                        report_mismatch("entry", k, t_comp'(got[k]), t_comp'(exp_mat[k]));
                end
            end
            mats_checked++;
        end
    end

    // nothing moving on either side for too long means a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("** quaternion_to_rotation_matrix: FAILED **");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_start       <= 1'b0;
        i_mode        <= 1'b0;
        i_quat_scalar <= '0;
        i_quat_x      <= '0;
        i_quat_y      <= '0;
        i_quat_z      <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 31;
        test_directed();
        test_unit_quats(220);
        test_raw_quats(200);
        send_idle_pct = 49;
        test_unit_quats(220);
        test_raw_quats(200);
        send_idle_pct = 0;
        test_unit_quats(220);
        test_raw_quats(200);

        i_start <= 1'b0;
        while (expected_mats.size() != 0) @(posedge i_clk);
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);

        $display("sent %0d quaternions (directed, unit rotations, raw patterns, both modes)",
                 words_sent);
        $display("checked %0d matrices, %0d entry mismatches", mats_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("** quaternion_to_rotation_matrix: PASSED **");
        end else begin
            $display("** quaternion_to_rotation_matrix: FAILED **");
        end
        $finish;
    end

endmodule

### quaternion_to_rotation_matrix.f
src/q2dcm_pkg.sv
src/quaternion_to_rotation_matrix.sv
tb/tb_quaternion_to_rotation_matrix.sv
